// File: rtl/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// Two-level page table package
// Widths, constants, codes and item types shared by the page table engine.
// ----------------------------------------------------------------------------
package tlpt_pkg;

	// Pool of page tables
	localparam int unsigned TABLE_SLOTS = 16;
	localparam int unsigned DIR_ENTRIES = 1024;
	localparam int unsigned TBL_ENTRIES = 1024;
	localparam int unsigned IDX_W       = 10;
	localparam int unsigned FRAME_W     = 20;
	localparam int unsigned OFFS_W      = 12;
	localparam int unsigned SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int unsigned CNT_W       = $clog2(TABLE_SLOTS + 1);
	localparam int unsigned TBL_DEPTH   = TABLE_SLOTS * TBL_ENTRIES;
	localparam int unsigned TBL_AW      = $clog2(TBL_DEPTH);

	// Entry layout
	localparam logic [31:0] FRAME_MASK  = 32'hFFFF_F000;
	localparam logic [31:0] LOW_MASK    = 32'h0000_0FFF;
	localparam logic [31:0] BIT_PRESENT = 32'h0000_0001;
	localparam logic [31:0] BIT_RW      = 32'h0000_0002;
	localparam logic [31:0] BIT_USER    = 32'h0000_0004;

	// Request codes
	localparam logic [1:0] REQ_MAP       = 2'd0;
	localparam logic [1:0] REQ_UNMAP     = 2'd1;
	localparam logic [1:0] REQ_TRANSLATE = 2'd2;

	// Status codes
	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_MISS    = 2'd1;
	localparam logic [1:0] STS_NO_SLOT = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] virt_addr;
		logic [31:0] phys_addr;
		logic [11:0] page_flags;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] phys_out;
		logic        table_created;
		logic        tlb_flush;
		logic [31:0] flush_addr;
	} rsp_t;

	// Memory port bundle from the sequencer
	typedef struct packed {
		logic              dir_we;
		logic [IDX_W-1:0]  dir_addr;
		logic [31:0]       dir_wdata;
		logic              tbl_we;
		logic [TBL_AW-1:0] tbl_addr;
		logic [31:0]       tbl_wdata;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PDE,
		ST_CLEAR,
		ST_PTE,
		ST_DONE
	} state_t;

endpackage

// File: rtl/tlpt_ram.sv
// ----------------------------------------------------------------------------
// Single-port synchronous RAM
// One access per cycle; a write reads the old word; read data registered.
// ----------------------------------------------------------------------------
module tlpt_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 32,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and read the addressed word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/tlpt_ctrl.sv
// ----------------------------------------------------------------------------
// Page table sequencer
// Walks directory then table memory where an item needs it, allocates and
// clears tables, sweeps both memories after reset and holds the result item.
// ----------------------------------------------------------------------------
module tlpt_ctrl
	import tlpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata,
	output mem_req_t    mem,
	input  logic [31:0] dir_rdata,
	input  logic [31:0] tbl_rdata
);

	state_t              state_q, state_d;
	logic [TBL_AW-1:0]   sweep_q;
	logic [FRAME_W-1:0]  base_q;
	logic [CNT_W-1:0]    next_slot_q;
	logic [SLOT_W-1:0]   alloc_slot_q;
	req_t                req_q;
	rsp_t                res_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic [IDX_W-1:0]    di, ti;
	logic                present, in_pool, pool_full, alloc;
	logic [FRAME_W-1:0]  slot_diff;
	logic [SLOT_W-1:0]   pde_slot;
	logic [31:0]         pte_map, pde_new;
	logic [FRAME_W-1:0]  new_frame;
	logic                sweep_last, clear_last, out_free;
	logic [SLOT_W+IDX_W-1:0] pde_tbl_addr, clr_tbl_addr;
	rsp_t                res_pde;

	// Decode the held item and the directory entry just read
	assign di         = req_q.virt_addr[31:22];
	assign ti         = req_q.virt_addr[21:12];
	assign present    = dir_rdata[0];
	assign slot_diff  = dir_rdata[31:12] - base_q;
	assign in_pool    = slot_diff < FRAME_W'(TABLE_SLOTS);
	assign pde_slot   = slot_diff[SLOT_W-1:0];
	assign pool_full  = next_slot_q >= CNT_W'(TABLE_SLOTS);
	assign alloc      = (req_q.req_type == REQ_MAP) && !present && !pool_full;
	assign new_frame  = base_q + FRAME_W'(next_slot_q);
	assign pte_map    = (req_q.phys_addr & FRAME_MASK)
	                  | ({20'd0, req_q.page_flags} & LOW_MASK) | BIT_PRESENT;
	assign pde_new    = {new_frame, 12'd0} | BIT_RW
	                  | ({20'd0, req_q.page_flags} & BIT_USER) | BIT_PRESENT;
	assign pde_tbl_addr = {pde_slot, ti};
	assign clr_tbl_addr = {alloc_slot_q, sweep_q[IDX_W-1:0]};
	assign sweep_last = sweep_q == TBL_AW'(TBL_DEPTH - 1);
	assign clear_last = sweep_q[IDX_W-1:0] == IDX_W'(TBL_ENTRIES - 1);
	assign out_free   = !rsp_valid_q || rsp_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_d = ST_PDE;
			end
			ST_PDE: begin
				if (alloc) begin
					state_d = ST_CLEAR;
				end else if (req_q.req_type == REQ_TRANSLATE && present && in_pool) begin
					state_d = ST_PTE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CLEAR: begin
				if (clear_last) state_d = ST_DONE;
			end
			ST_PTE: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Memory accesses and input handshake
	always_comb begin
		req_ready     = 1'b0;
		mem.dir_we    = 1'b0;
		mem.dir_addr  = di;
		mem.dir_wdata = '0;
		mem.tbl_we    = 1'b0;
		mem.tbl_addr  = TBL_AW'(pde_tbl_addr);
		mem.tbl_wdata = '0;
		unique case (state_q)
			ST_INIT: begin
				mem.dir_we   = {1'b0, sweep_q} < (TBL_AW + 1)'(DIR_ENTRIES);
				mem.dir_addr = sweep_q[IDX_W-1:0];
				mem.tbl_we   = 1'b1;
				mem.tbl_addr = sweep_q;
			end
			ST_IDLE: begin
				req_ready    = 1'b1;
				mem.dir_addr = req.virt_addr[31:22];
			end
			ST_PDE: begin
				case (req_q.req_type)
					REQ_MAP: begin
						mem.tbl_we    = present && in_pool;
						mem.tbl_wdata = pte_map;
						mem.dir_we    = alloc;
						mem.dir_wdata = pde_new;
					end
					REQ_UNMAP: begin
						mem.tbl_we = present && in_pool;
					end
					default: ;
				endcase
			end
			ST_CLEAR: begin
				mem.tbl_we    = 1'b1;
				mem.tbl_addr  = TBL_AW'(clr_tbl_addr);
				mem.tbl_wdata = (sweep_q[IDX_W-1:0] == ti) ? pte_map : '0;
			end
			ST_PTE, ST_DONE: ;
			default: ;
		endcase
	end

	// Build the result of the directory step
	always_comb begin
		res_pde = '0;
		case (req_q.req_type)
			REQ_MAP: begin
				if (!present && pool_full) begin
					res_pde.status = STS_NO_SLOT;
				end else begin
					res_pde.table_created = !present;
					res_pde.tlb_flush     = 1'b1;
					res_pde.flush_addr    = req_q.virt_addr;
				end
			end
			REQ_UNMAP: begin
				if (present) begin
					res_pde.tlb_flush  = 1'b1;
					res_pde.flush_addr = req_q.virt_addr;
				end
			end
			REQ_TRANSLATE: begin
				if (!(present && in_pool)) res_pde.status = STS_MISS;
			end
			default: ;
		endcase
	end

	// State, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			base_q      <= '0;
			next_slot_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) base_q <= cfg_wdata;
			if (state_q == ST_INIT || state_q == ST_CLEAR) begin
				sweep_q <= sweep_q + 1'b1;
			end else if (state_q == ST_PDE) begin
				sweep_q <= '0;
			end
			if (state_q == ST_PDE && alloc) next_slot_q <= next_slot_q + 1'b1;
		end
	end

	// Hold the item and build its result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) req_q <= req;
		if (state_q == ST_PDE) begin
			alloc_slot_q <= SLOT_W'(next_slot_q);
			res_q        <= res_pde;
		end
		if (state_q == ST_PTE) begin
			if (tbl_rdata[0]) begin
				res_q.phys_out <= (tbl_rdata & FRAME_MASK) | (req_q.virt_addr & LOW_MASK);
			end else begin
				res_q.status <= STS_MISS;
			end
		end
		if (state_q == ST_DONE && out_free) rsp_q <= res_q;
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/two_level_page_table_engine.sv
// ----------------------------------------------------------------------------
// Two-level page table engine
// Page directory and page table pool in synchronous memories, 10/10/12 split.
// Map and unmap use the directory step alone; translate adds a table read step.
// A map that allocates a table clears its 1024 entries first.
// No new item is taken until the last item's result is in the output register;
// a stalled result item holds it back. After reset both memories are swept to
// zero before the first item is taken; configuration writes go on.
// ----------------------------------------------------------------------------
module two_level_page_table_engine
	import tlpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata
);

	mem_req_t    mem;
	logic [31:0] dir_rdata;
	logic [31:0] tbl_rdata;

	// Sequencer
	tlpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mem       (mem),
		.dir_rdata (dir_rdata),
		.tbl_rdata (tbl_rdata)
	);

	// Page directory
	tlpt_ram #(
		.DEPTH (DIR_ENTRIES),
		.WIDTH (32)
	) u_dir_ram (
		.clk   (clk),
		.we    (mem.dir_we),
		.addr  (mem.dir_addr),
		.wdata (mem.dir_wdata),
		.rdata (dir_rdata)
	);

	// Page table pool
	tlpt_ram #(
		.DEPTH (TBL_DEPTH),
		.WIDTH (32)
	) u_tbl_ram (
		.clk   (clk),
		.we    (mem.tbl_we),
		.addr  (mem.tbl_addr),
		.wdata (mem.tbl_wdata),
		.rdata (tbl_rdata)
	);

endmodule

// File: tb/tlpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table engine checker
// Keeps its own copy of the page directory, the table pool, the slot count and
// the pool base. Predicts the response item for every accepted request item
// and compares each accepted response item, field by field, in order.
// ----------------------------------------------------------------------------
module tlpt_checker
	import tlpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);

	localparam int MAX_PRINTS = 40;

	logic [31:0]        shadow_dir  [DIR_ENTRIES];
	logic [31:0]        shadow_pool [TBL_DEPTH];
	int unsigned        slots_used;
	logic [FRAME_W-1:0] base_frame;
	rsp_t               expected_rsp_q [$];

	// Start from the post-reset picture: everything zero
	initial begin
		for (int i = 0; i < DIR_ENTRIES; i++) shadow_dir[i] = '0;
		for (int i = 0; i < TBL_DEPTH; i++) shadow_pool[i] = '0;
		slots_used = 0;
		base_frame = '0;
		fail_count = 0;
		pending    = 0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fail_count++;
		if (fail_count <= MAX_PRINTS)
			$display("%0d ns: %s: got %h, expected %h", $time, what, got, want);
	endtask

	// Pool slot behind a present PDE; TABLE_SLOTS when it lies outside the pool
	function automatic int unsigned pool_slot(input logic [31:0] pde);
		logic [FRAME_W-1:0] slot_off;
		slot_off = pde[31:12] - base_frame;
		if (slot_off < FRAME_W'(TABLE_SLOTS)) return 32'(slot_off);
		return TABLE_SLOTS;
	endfunction

	// Write a table entry; drop writes to tables outside the pool
	task automatic write_entry(input logic [31:0] pde, input logic [IDX_W-1:0] tbl_idx,
			input logic [31:0] value);
		int unsigned slot;
		slot = pool_slot(pde);
		if (slot < TABLE_SLOTS) shadow_pool[slot * TBL_ENTRIES + tbl_idx] = value;
	endtask

	// Walk the shadow tables for one request item and update them
	task automatic predict_walk(input req_t item, output rsp_t want);
		logic [IDX_W-1:0]   dir_idx;
		logic [IDX_W-1:0]   tbl_idx;
		logic [31:0]        pde;
		logic [31:0]        pte;
		logic [31:0]        flags32;
		logic [FRAME_W-1:0] frame;
		int unsigned        slot;
		bit                 room;
		dir_idx = item.virt_addr[31:22];
		tbl_idx = item.virt_addr[21:12];
		pde     = shadow_dir[dir_idx];
		flags32 = {20'h0, item.page_flags};
		want    = '0;
		case (item.req_type)
		REQ_MAP: begin
			room = 1'b1;
			if ((pde & BIT_PRESENT) == 32'h0) begin
				if (slots_used >= TABLE_SLOTS) begin
					room = 1'b0;
					want.status = STS_NO_SLOT;
				end else begin
					frame = base_frame + slots_used[FRAME_W-1:0];
					for (int k = 0; k < TBL_ENTRIES; k++)
						shadow_pool[slots_used * TBL_ENTRIES + k] = '0;
					pde = {frame, 12'h000} | BIT_RW | (flags32 & BIT_USER) | BIT_PRESENT;
					shadow_dir[dir_idx] = pde;
					slots_used++;
					want.table_created = 1'b1;
				end
			end
			if (room) begin
				write_entry(pde, tbl_idx, (item.phys_addr & FRAME_MASK) | flags32 | BIT_PRESENT);
				want.tlb_flush  = 1'b1;
				want.flush_addr = item.virt_addr;
			end
		end
		REQ_UNMAP: begin
			if ((pde & BIT_PRESENT) != 32'h0) begin
				write_entry(pde, tbl_idx, 32'h0);
				want.tlb_flush  = 1'b1;
				want.flush_addr = item.virt_addr;
			end
		end
		REQ_TRANSLATE: begin
			pte = '0;
			if ((pde & BIT_PRESENT) != 32'h0) begin
				slot = pool_slot(pde);
				if (slot < TABLE_SLOTS) pte = shadow_pool[slot * TBL_ENTRIES + tbl_idx];
			end
			if ((pte & BIT_PRESENT) != 32'h0)
				want.phys_out = (pte & FRAME_MASK) | (item.virt_addr & LOW_MASK);
			else
				want.status = STS_MISS;
		end
		default: begin
			// unknown request: all-zero response
		end
		endcase
	endtask

	// Predict on each accepted request item, compare on each response item
	always @(posedge clk) begin : watch
		rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				predict_walk(req, want);
				expected_rsp_q.push_back(want);
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("response item with nothing expected", rsp.phys_out, 32'h0);
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.phys_out !== want.phys_out)
						report_mismatch("phys_out", rsp.phys_out, want.phys_out);
					if (rsp.table_created !== want.table_created)
						report_mismatch("table_created", 32'(rsp.table_created),
							32'(want.table_created));
					if (rsp.tlb_flush !== want.tlb_flush)
						report_mismatch("tlb_flush", 32'(rsp.tlb_flush), 32'(want.tlb_flush));
					if (rsp.flush_addr !== want.flush_addr)
						report_mismatch("flush_addr", rsp.flush_addr, want.flush_addr);
				end
			end
			if (cfg_we) base_frame = cfg_wdata;
			pending = expected_rsp_q.size();
		end
	end

endmodule

// File: tb/two_level_page_table_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level page table engine testbench
// Drives map, unmap, translate and unknown request items in bursts against a stalling
// response side, across several pool base settings including both extremes.
// A checker beside the engine predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_tb;
	import tlpt_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN   = 2'd3;
	localparam int         QUIET_LIMIT   = 60000;
	localparam int         PHASES        = 5;
	localparam int         ITEMS_A_PHASE = 270;
	localparam int         HOT_DIRS      = 24;

	typedef enum int {
		DRAIN_FREE,
		DRAIN_COIN,
		DRAIN_CADENCE,
		DRAIN_SPARSE
	} drain_mode_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	logic        cfg_we;
	logic [19:0] cfg_wdata;
	int          fail_count;
	int          pending;

	logic [IDX_W-1:0] hot_dir [HOT_DIRS];
	int               burst_left;

	two_level_page_table_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	tlpt_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic req_t make_req(input logic [1:0] kind, input logic [31:0] va,
			input logic [31:0] pa, input logic [11:0] flags);
		req_t item;
		item.req_type   = kind;
		item.virt_addr  = va;
		item.phys_addr  = pa;
		item.page_flags = flags;
		return item;
	endfunction

	// Mostly addresses in a few hot directory entries and low table entries,
	// so that maps, translates and unmaps meet; a little noise on top
	function automatic req_t random_req(input int hot_n);
		req_t             item;
		int               pick;
		logic [IDX_W-1:0] dir_idx;
		logic [IDX_W-1:0] tbl_idx;
		pick = $urandom_range(0, 99);
		if (pick < 40)      item.req_type = REQ_MAP;
		else if (pick < 55) item.req_type = REQ_UNMAP;
		else if (pick < 95) item.req_type = REQ_TRANSLATE;
		else                item.req_type = REQ_UNKNOWN;
		item.phys_addr  = $urandom;
		item.page_flags = 12'($urandom);
		if ($urandom_range(0, 29) == 0 &&
				(item.req_type != REQ_MAP || $urandom_range(0, 9) == 0)) begin
			item.virt_addr = $urandom;
		end else begin
			dir_idx = hot_dir[$urandom_range(0, hot_n - 1)];
			if ($urandom_range(0, 3) == 0) tbl_idx = 10'($urandom_range(0, 1023));
			else tbl_idx = 10'($urandom_range(0, 15));
			item.virt_addr = {dir_idx, tbl_idx, 12'($urandom)};
		end
		return item;
	endfunction

	// Present one item; bursts of random length with random gaps between them
	task automatic send_item(input req_t item);
		int gap;
		if (burst_left == 0) begin
			if (req_valid) begin
				req_valid <= 1'b0;
				gap = $urandom_range(1, 12);
				repeat (gap) @(negedge clk);
			end
			if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 120);
			else burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	// Write the pool base only once every response item is back
	task automatic write_base(input logic [19:0] value);
		req_valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Extremes of the fields, every request kind, misses and the unknown code
	task automatic run_directed();
		send_item(make_req(REQ_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000));
		send_item(make_req(REQ_UNMAP,     32'h0000_0000, 32'h0, 12'h000));
		send_item(make_req(REQ_MAP,       32'h0000_0000, 32'hFFFF_FFFF, 12'hFFE));
		send_item(make_req(REQ_TRANSLATE, 32'h0000_0FFF, 32'h0, 12'h000));
		send_item(make_req(REQ_MAP,       32'hFFFF_FFFF, 32'h0000_0000, 12'h000));
		send_item(make_req(REQ_TRANSLATE, 32'hFFFF_F000, 32'hFFFF_FFFF, 12'hFFF));
		send_item(make_req(REQ_TRANSLATE, 32'h0000_1000, 32'h0, 12'h000));
		send_item(make_req(REQ_UNMAP,     32'h0000_0123, 32'h0, 12'h000));
		send_item(make_req(REQ_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000));
		send_item(make_req(REQ_UNKNOWN,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
		send_item(make_req(REQ_MAP,       32'h003F_F000, 32'h1234_5000, 12'hFFF));
		send_item(make_req(REQ_TRANSLATE, 32'h003F_FABC, 32'h0, 12'h000));
		send_item(make_req(REQ_UNMAP,     32'hFFFF_FFFF, 32'h0, 12'h000));
		send_item(make_req(REQ_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 12'h000));
		send_item(make_req(REQ_MAP,       32'hFFC0_0000, 32'hABCD_E123, 12'h001));
		send_item(make_req(REQ_TRANSLATE, 32'hFFC0_0FFF, 32'h0, 12'h000));
		send_item(make_req(REQ_UNKNOWN,   32'h0000_0000, 32'h0, 12'h000));
	endtask

	// Stimulus and verdict
	initial begin : stimulus
		logic [19:0] phase_base [PHASES];
		req_valid  = 1'b0;
		req        = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		arst_n     = 1'b0;
		burst_left = 0;
		hot_dir[0] = 10'd0;
		hot_dir[1] = 10'd1023;
		for (int i = 2; i < HOT_DIRS; i++) hot_dir[i] = 10'(i * 41 + $urandom_range(0, 40));
		// Top of the frame space first, so that the second slot wraps to frame 0
		phase_base[0] = 20'hFFFFF;
		phase_base[1] = 20'h00000;
		phase_base[2] = 20'($urandom_range(0, 20'hFFFFF));
		phase_base[3] = 20'hFFFF8;
		phase_base[4] = 20'h00004;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			write_base(phase_base[p]);
			if (p == 0) run_directed();
			repeat (ITEMS_A_PHASE) send_item(random_req(6 + 4 * p));
		end
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Response side stalls on patterns of its own, chosen anew every segment
	initial begin : drain
		drain_mode_t mode;
		int          seg;
		int          tick;
		rsp_ready = 1'b0;
		tick      = 0;
		forever begin
			mode = drain_mode_t'($urandom_range(0, 3));
			seg  = $urandom_range(20, 200);
			repeat (seg) begin
				@(negedge clk);
				tick++;
				case (mode)
				DRAIN_FREE:    rsp_ready <= 1'b1;
				DRAIN_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
				DRAIN_CADENCE: rsp_ready <= (tick % 3) != 0;
				default:       rsp_ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// End the run when no item moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
			else quiet++;
		end
		$display("FAILURE");
		$finish;
	end

endmodule
